/* hdl/bole_pkg.sv */
package bole_pkg;

  localparam int DEF_ENTRIES  = 128;
  localparam int DEF_KEY_BITS = 32;
  localparam logic [7:0] CAP_RESET = 8'd100;
  localparam int ADDR_W = 3;

  // command kinds
  localparam logic [2:0] K_APPEND = 3'd0;
  localparam logic [2:0] K_INSERT = 3'd1;
  localparam logic [2:0] K_REMOVE = 3'd2;
  localparam logic [2:0] K_DELETE = 3'd3;
  localparam logic [2:0] K_FIND   = 3'd4;
  localparam logic [2:0] K_READ   = 3'd5;

  // result status
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NOTFND = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic load;
    logic walk;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
  } sts_t;

endpackage

/* hdl/bounded_ordered_list_engine.sv */
// Bounded ordered list engine: positional list of key/handle entries in one memory.
// Insert, remove, delete and find walk over the stored entries between start and result strobe;
//   one memory read and one write per cycle bound the walk.
// Throughput: one command at a time; busy is high until the result is issued.
// The result strobe is high for one cycle; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the list and sets capacity_limit to 100.
module bounded_ordered_list_engine import bole_pkg::*; #(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command transfer
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] key_i,
  input  logic [31:0]        element_ref_i,
  // result transfer
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] found_key_o,
  output logic [31:0]        found_ref_o,
  output logic [7:0]         entry_count_o,
  output logic               is_empty_o,
  output logic               is_full_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cmd_t       cmd;
  sts_t       sts;
  logic [7:0] cap;
  logic       cfg_we;

  // only capacity_limit is mapped, at byte addresses 0 to 3 (paddr[2] low)
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {24'd0, cap};

  bole_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // memory, count, capacity and the walk over stored entries
  bole_datapath #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (kind_i),
    .position_i     (position_i),
    .key_i          (key_i),
    .element_ref_i  (element_ref_i),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata[7:0]),
    .cap_o          (cap),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .found_key_o    (found_key_o),
    .found_ref_o    (found_ref_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o)
  );

endmodule

/* hdl/bole_ctrl.sv */
module bole_ctrl import bole_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_done) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef SYNTH
  a_load_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !busy_o) else $error("load while busy");
  a_fin_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |-> $past(cmd_o.walk)) else $error("fin without walk");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.walk, cmd_o.fin})) else $error("command overlap");
`endif

endmodule

/* hdl/bole_datapath.sv */
module bole_datapath import bole_pkg::*; #(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [2:0]         kind_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] key_i,
  input  logic [31:0]        element_ref_i,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  output logic [7:0]         cap_o,
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] found_key_o,
  output logic [31:0]        found_ref_o,
  output logic [7:0]         entry_count_o,
  output logic               is_empty_o,
  output logic               is_full_o
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = ((CW > 8) ? CW : 8) + 1;
  localparam int DW = KEY_BITS + 32;

  logic [DW-1:0] mem [ENTRIES];
  logic [DW-1:0] rdata_q;

  logic [CW-1:0]       count_q, w_q, left_q, cnt_next;
  logic [7:0]          cap_q;
  logic [2:0]          op_q;
  logic [KEY_BITS-1:0] key_q, fkey_q;
  logic [31:0]         ref_q, fref_q;
  logic [AW-1:0]       pos_idx_q, rd_idx_q, pend_addr_q;
  logic                err_q, up_q, pend_q, hit_q;
  logic [1:0]          err_st_q, st_fin;

  logic [LW-1:0] cnt_w, pos_w, cap_w;
  logic          full;
  logic          err_d;
  logic [1:0]    err_st_d;
  logic [CW-1:0] left_d;
  logic [AW-1:0] rd_start;

  logic                we, re;
  logic [AW-1:0]       waddr;
  logic [DW-1:0]       wdata;
  logic [KEY_BITS-1:0] rkey;

  assign cnt_w = LW'(count_q);
  assign pos_w = LW'(position_i);
  assign cap_w = (LW'(cap_q) < LW'(ENTRIES)) ? LW'(cap_q) : LW'(ENTRIES);
  assign full  = (cnt_w >= cap_w);
  assign rkey  = rdata_q[DW-1:32];
  assign cap_o = cap_q;

  // command checks at load
  always_comb begin
    err_d    = 1'b0;
    err_st_d = ST_OK;
    left_d   = '0;
    rd_start = '0;
    case (kind_i)
      K_APPEND: begin
        if (full) begin err_d = 1'b1; err_st_d = ST_FULL; end
      end
      K_INSERT: begin
        if (full) begin
          err_d = 1'b1; err_st_d = ST_FULL;
        end else if (pos_w == '0 || pos_w > cnt_w + LW'(1)) begin
          err_d = 1'b1; err_st_d = ST_BADPOS;
        end
        left_d   = CW'(cnt_w - pos_w + LW'(1));
        rd_start = AW'(cnt_w - LW'(1));
      end
      K_REMOVE: begin
        if (count_q == '0) begin
          err_d = 1'b1; err_st_d = ST_NOTFND;
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          err_d = 1'b1; err_st_d = ST_BADPOS;
        end
        left_d   = CW'(cnt_w - pos_w);
        rd_start = AW'(pos_w);
      end
      K_DELETE, K_FIND: begin
        left_d = count_q;
      end
      K_READ: begin
        if (pos_w == '0 || pos_w > cnt_w) begin
          err_d = 1'b1; err_st_d = ST_BADPOS;
        end
        left_d   = CW'(1);
        rd_start = AW'(pos_w - LW'(1));
      end
      default: ;
    endcase
    if (err_d) left_d = '0;
  end

  // memory write port
  always_comb begin
    we    = 1'b0;
    waddr = AW'(count_q);
    wdata = rdata_q;
    if (cmd_i.walk && pend_q) begin
      case (op_q)
        K_INSERT: begin we = 1'b1; waddr = pend_addr_q + AW'(1); end
        K_REMOVE: begin we = 1'b1; waddr = pend_addr_q - AW'(1); end
        K_DELETE: begin
          we    = (rkey != key_q);
          waddr = AW'(w_q);
        end
        default: ;
      endcase
    end else if (cmd_i.fin && !err_q) begin
      case (op_q)
        K_APPEND: begin we = 1'b1; waddr = AW'(count_q); wdata = {key_q, ref_q}; end
        K_INSERT: begin we = 1'b1; waddr = pos_idx_q; wdata = {key_q, ref_q}; end
        default: ;
      endcase
    end
  end

  assign re = cmd_i.walk && (left_q != '0);

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[rd_idx_q];
  end

  assign sts_o.walk_done = (left_q == '0) && !pend_q;

  // final count and status
  always_comb begin
    cnt_next = count_q;
    st_fin   = ST_OK;
    if (err_q) begin
      st_fin = err_st_q;
    end else begin
      case (op_q)
        K_APPEND, K_INSERT: cnt_next = count_q + CW'(1);
        K_REMOVE: cnt_next = count_q - CW'(1);
        K_DELETE: begin
          cnt_next = w_q;
          st_fin   = (w_q == count_q) ? ST_NOTFND : ST_OK;
        end
        K_FIND: st_fin = hit_q ? ST_OK : ST_NOTFND;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      cap_q          <= CAP_RESET;
      pend_q         <= 1'b0;
      left_q         <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.fin;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        left_q <= left_d;
        pend_q <= 1'b0;
      end else if (cmd_i.walk) begin
        pend_q <= (left_q != '0);
        if (left_q != '0) left_q <= left_q - CW'(1);
      end
      if (cmd_i.fin) count_q <= cnt_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= kind_i;
      key_q     <= KEY_BITS'(key_i);
      ref_q     <= element_ref_i;
      pos_idx_q <= AW'(pos_w - LW'(1));
      err_q     <= err_d;
      err_st_q  <= err_st_d;
      rd_idx_q  <= rd_start;
      up_q      <= (kind_i != K_INSERT);
      w_q       <= '0;
      hit_q     <= 1'b0;
    end else if (cmd_i.walk) begin
      if (left_q != '0) begin
        pend_addr_q <= rd_idx_q;
        rd_idx_q    <= up_q ? rd_idx_q + AW'(1) : rd_idx_q - AW'(1);
      end
      if (pend_q) begin
        case (op_q)
          K_DELETE: if (rkey != key_q) w_q <= w_q + CW'(1);
          K_FIND: begin
            if (!hit_q && rkey == key_q) begin
              hit_q  <= 1'b1;
              fkey_q <= rkey;
              fref_q <= rdata_q[31:0];
            end
          end
          K_READ: begin
            hit_q  <= 1'b1;
            fkey_q <= rkey;
            fref_q <= rdata_q[31:0];
          end
          default: ;
        endcase
      end
    end
    if (cmd_i.fin) begin
      status_o      <= st_fin;
      entry_count_o <= 8'(cnt_next);
      is_empty_o    <= (cnt_next == '0);
      is_full_o     <= (LW'(cnt_next) >= cap_w);
      if (st_fin == ST_OK && (op_q == K_FIND || op_q == K_READ)) begin
        found_key_o <= 32'($signed(fkey_q));
        found_ref_o <= fref_q;
      end else begin
        found_key_o <= '0;
        found_ref_o <= '0;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(count_q) <= LW'(ENTRIES)) else $error("count past depth");
  a_strobe_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |=> result_valid_o) else $error("missing result strobe");
  a_write_in_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (cmd_i.walk || cmd_i.fin)) else $error("stray memory write");
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cmd_i.fin) |-> $stable(count_q)) else $error("count moved outside fin");
`endif

endmodule
